// File: design/ias_pkg.sv
// ============================================================================
// ias_pkg
// Shared codes and types for the indexed array with insert, delete and sort.
// ============================================================================
package ias_pkg;

    // Operation codes carried in the mode field of an input word.
    localparam logic [2:0] MODE_PUSH   = 3'd0;
    localparam logic [2:0] MODE_INSERT = 3'd1;
    localparam logic [2:0] MODE_DELETE = 3'd2;
    localparam logic [2:0] MODE_GET    = 3'd3;
    localparam logic [2:0] MODE_SET    = 3'd4;
    localparam logic [2:0] MODE_SORT   = 3'd5;
    localparam logic [2:0] MODE_CLEAR  = 3'd6;

    // Status codes of a result word.
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_RANGE = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    // Commands broadcast to every cell of the chain.
    localparam logic [2:0] CELL_HOLD   = 3'd0;
    localparam logic [2:0] CELL_INSERT = 3'd1;
    localparam logic [2:0] CELL_DELETE = 3'd2;
    localparam logic [2:0] CELL_SET    = 3'd3;
    localparam logic [2:0] CELL_SORT   = 3'd4;

    localparam int WORD_W = 32;

    typedef struct packed {
        logic [2:0]        op;     // cell command
        logic [WORD_W-1:0] value;  // word written by insert or set
        logic              desc;   // sort direction, 1 for descending
        logic              phase;  // odd-even transposition phase
    } cell_ctrl_t;

endpackage

// File: design/ias_cell.sv
// ============================================================================
// ias_cell
// One entry of the array chain: shifts, writes and compare-exchanges.
// ============================================================================
module ias_cell
    import ias_pkg::*;
#(
    parameter int CELL_INDEX = 0,
    parameter int PW         = 6
) (
    input  logic              aclk,
    input  cell_ctrl_t        ctrl,
    input  logic [PW-1:0]     sel_pos,
    input  logic [PW-1:0]     count,
    input  logic [WORD_W-1:0] dn_data,
    input  logic              dn_swap,
    input  logic [WORD_W-1:0] up_data,
    output logic [WORD_W-1:0] data,
    output logic              swap_up,
    output logic              order_ok,
    output logic [WORD_W-1:0] rd_data
);

    localparam logic [PW-1:0] MY_IDX   = PW'(CELL_INDEX);
    localparam logic [PW-1:0] NEXT_IDX = PW'(CELL_INDEX + 1);
    localparam logic          MY_PAR   = 1'(CELL_INDEX % 2);

    logic [WORD_W-1:0] entry_reg;
    logic [WORD_W-1:0] entry_next;
    logic              pair_valid;
    logic              gt_up;
    logic              lt_up;

    assign pair_valid = (NEXT_IDX < count);
    assign gt_up      = ($signed(entry_reg) > $signed(up_data));
    assign lt_up      = ($signed(entry_reg) < $signed(up_data));

    // This cell is the lower partner of its pair in the current phase.
    assign swap_up  = (ctrl.op == CELL_SORT) && (MY_PAR == ctrl.phase) && pair_valid &&
                      (ctrl.desc ? lt_up : gt_up);
    assign order_ok = !pair_valid || !gt_up;
    assign rd_data  = (MY_IDX == sel_pos) ? entry_reg : '0;
    assign data     = entry_reg;

    always_comb begin
        entry_next = entry_reg;
        unique case (ctrl.op)
            CELL_INSERT: begin
                if (MY_IDX == sel_pos) begin
                    entry_next = ctrl.value;
                end else if (MY_IDX > sel_pos) begin
                    entry_next = dn_data;
                end
            end
            CELL_DELETE: begin
                if (MY_IDX >= sel_pos) begin
                    entry_next = up_data;
                end
            end
            CELL_SET: begin
                if (MY_IDX == sel_pos) begin
                    entry_next = ctrl.value;
                end
            end
            CELL_SORT: begin
                if (swap_up) begin
                    entry_next = up_data;
                end else if (dn_swap) begin
                    entry_next = dn_data;
                end
            end
            default: begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

// File: design/indexed_array_insert_delete_sort_top.sv
// ============================================================================
// indexed_array_insert_delete_sort_top
// Bounded array of signed words in a chain of cells, with insert, delete,
// get, set, sort and clear.
// ============================================================================
//
//  Channel  Direction  Word layout (lowest bit first)
//  s_       in         mode[2:0] position[8:3] value[40:9] descending[41]
//  m_       out        read_value[31:0] status[33:32] count[39:34]
//                      is_empty[40] is_sorted[41]
//
// Every accepted word yields exactly one result word. For push, insert, delete,
// get, set and clear the chain updates in the accept cycle and the flags are
// taken from the new state in SM_DONE, when the result is loaded. Sort runs one
// odd-even transposition round per cycle over the occupied cells, for two or
// more entries, before SM_DONE. One word is worked on at a time; a new word is
// taken while the previous result still waits on m_tready. Reset is synchronous,
// active low, and empties the array; the cell contents are not cleared.
//
module indexed_array_insert_delete_sort_top
    import ias_pkg::*;
#(
    parameter int CAPACITY = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // mode, position, value, descending, zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // read_value, status, count, is_empty, is_sorted, zero fill
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int PW    = (CNT_W > 6) ? CNT_W : 6;
    localparam logic [PW-1:0] CAP_W = PW'(CAPACITY);

    // Sequencer states.
    localparam logic [1:0] SM_IDLE = 2'd0;
    localparam logic [1:0] SM_SORT = 2'd1;
    localparam logic [1:0] SM_DONE = 2'd2;

    // Input word fields.
    logic [2:0]        in_mode;
    logic [5:0]        in_position;
    logic [WORD_W-1:0] in_value;
    logic              in_desc;

    assign in_mode     = s_tdata[2:0];
    assign in_position = s_tdata[8:3];
    assign in_value    = s_tdata[40:9];
    assign in_desc     = s_tdata[41];

    logic [1:0]        state_reg,  state_next;
    logic [CNT_W-1:0]  count_reg,  count_next;
    logic [CNT_W-1:0]  round_reg,  round_next;
    logic              desc_reg,   desc_next;
    logic [WORD_W-1:0] rd_reg,     rd_next;
    logic [1:0]        status_reg, status_next;
    logic              m_valid_reg, m_valid_next;
    logic [41:0]       m_word_reg, m_word_next;

    cell_ctrl_t        ctrl;
    logic [PW-1:0]     sel_pos;
    logic [PW-1:0]     count_w;
    logic [PW-1:0]     pos_w;
    logic              accept;
    logic [WORD_W-1:0] read_word;
    logic              all_ordered;

    logic [WORD_W-1:0] cell_data [CAPACITY];
    logic [WORD_W-1:0] cell_rd   [CAPACITY];
    logic              cell_swap [CAPACITY];
    logic              cell_ok   [CAPACITY];

    assign count_w  = PW'(count_reg);
    assign pos_w    = PW'(in_position);
    assign s_tready = (state_reg == SM_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, m_word_reg};

    // The chain of cells; each cell sees its two neighbors.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [WORD_W-1:0] dn_d;
        logic              dn_s;
        logic [WORD_W-1:0] up_d;

        if (g == 0) begin : g_first
            assign dn_d = '0;
            assign dn_s = 1'b0;
        end else begin : g_inner
            assign dn_d = cell_data[g-1];
            assign dn_s = cell_swap[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign up_d = '0;
        end else begin : g_body
            assign up_d = cell_data[g+1];
        end

        ias_cell #(
            .CELL_INDEX (g),
            .PW         (PW)
        ) u_cell (
            .aclk     (aclk),
            .ctrl     (ctrl),
            .sel_pos  (sel_pos),
            .count    (count_w),
            .dn_data  (dn_d),
            .dn_swap  (dn_s),
            .up_data  (up_d),
            .data     (cell_data[g]),
            .swap_up  (cell_swap[g]),
            .order_ok (cell_ok[g]),
            .rd_data  (cell_rd[g])
        );
    end

    // Only the selected cell drives a nonzero read word, so an OR gathers it.
    always_comb begin
        read_word   = '0;
        all_ordered = 1'b1;
        for (int i = 0; i < CAPACITY; i++) begin
            read_word   = read_word | cell_rd[i];
            all_ordered = all_ordered & cell_ok[i];
        end
    end

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        round_next   = round_reg;
        desc_next    = desc_reg;
        rd_next      = rd_reg;
        status_next  = status_reg;
        m_valid_next = m_valid_reg;
        m_word_next  = m_word_reg;

        ctrl.op    = CELL_HOLD;
        ctrl.value = in_value;
        ctrl.desc  = desc_reg;
        ctrl.phase = round_reg[0];
        sel_pos    = pos_w;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            SM_IDLE: begin
                if (accept) begin
                    rd_next     = '0;
                    status_next = STATUS_OK;
                    state_next  = SM_DONE;
                    case (in_mode)
                        MODE_PUSH: begin
                            if (count_w == CAP_W) begin
                                status_next = STATUS_FULL;
                            end else begin
                                ctrl.op    = CELL_INSERT;
                                sel_pos    = count_w;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        MODE_INSERT: begin
                            if (pos_w > count_w) begin
                                status_next = STATUS_RANGE;
                            end else if (count_w == CAP_W) begin
                                status_next = STATUS_FULL;
                            end else begin
                                ctrl.op    = CELL_INSERT;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        MODE_DELETE: begin
                            if (pos_w >= count_w) begin
                                status_next = STATUS_RANGE;
                            end else begin
                                ctrl.op    = CELL_DELETE;
                                count_next = count_reg - 1'b1;
                            end
                        end
                        MODE_GET: begin
                            if (pos_w >= count_w) begin
                                status_next = STATUS_RANGE;
                            end else begin
                                rd_next = read_word;
                            end
                        end
                        MODE_SET: begin
                            if (pos_w >= count_w) begin
                                status_next = STATUS_RANGE;
                            end else begin
                                ctrl.op = CELL_SET;
                            end
                        end
                        MODE_SORT: begin
                            if (count_reg >= CNT_W'(2)) begin
                                desc_next  = in_desc;
                                round_next = '0;
                                state_next = SM_SORT;
                            end
                        end
                        MODE_CLEAR: begin
                            count_next = '0;
                        end
                        default: begin
                        end
                    endcase
                    if (status_next == STATUS_RANGE) begin
                        rd_next = '1;
                    end
                end
            end
            SM_SORT: begin
                // n rounds of odd-even transposition order n entries.
                ctrl.op    = CELL_SORT;
                round_next = round_reg + 1'b1;
                if (round_reg == count_reg - 1'b1) begin
                    state_next = SM_DONE;
                end
            end
            SM_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_word_next  = {(count_reg != '0) && all_ordered,
                                    (count_reg == '0),
                                    6'(count_reg),
                                    status_reg,
                                    rd_reg};
                    state_next   = SM_IDLE;
                end
            end
            default: begin
                state_next = SM_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= SM_IDLE;
            count_reg   <= '0;
            round_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            round_reg   <= round_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        desc_reg   <= desc_next;
        rd_reg     <= rd_next;
        status_reg <= status_next;
        m_word_reg <= m_word_next;
    end

endmodule

// File: design/ias_checker.sv
// ============================================================================
// ias_checker
// Port-level checks of the indexed array block.
// ============================================================================
module ias_checker
    import ias_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata
);

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // One word is worked on at a time.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a word is in flight");

    // A range error always reads back minus one.
    a_range_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[33:32] == STATUS_RANGE) |-> (m_tdata[31:0] == 32'hFFFF_FFFF))
        else $error("range error without minus one");

    // An empty array shows no count and is never reported as sorted.
    a_empty_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[40] |-> (m_tdata[39:34] == 6'd0) && !m_tdata[41])
        else $error("empty flag inconsistent with count or sorted flag");

    // A full status is never raised on an empty array and reads zero.
    a_full_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[33:32] == STATUS_FULL) |-> !m_tdata[40] && (m_tdata[31:0] == '0))
        else $error("full status inconsistent");

endmodule

bind indexed_array_insert_delete_sort_top ias_checker u_ias_checker (.*);
